// ===== src/dsl_pkg.sv =====
// Shared constants and types for the descending sorted list.
package dsl_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VALUE_W = 32;
   localparam int IDX_W = 4;
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic insert_en;
      logic delete_en;
      logic signed [VALUE_W-1:0] value;
      logic [IDX_W-1:0] index;
      logic [CNT_W-1:0] count;
   } cell_ctl_type;

endpackage

// ===== src/descending_sorted_list_top.sv =====
// Top level of the descending sorted list: cell row, count and result register.
//
//   channel | direction | fields
//   req_    | in        | cmd, value, index
//   rsp_    | out       | status, count, read_value
//
// Every command passes the row of cells at once: all slots compare with the
// value and shift in the same edge, so one beat is taken per cycle unless a
// held response stalls it. The result is held in a register from the cycle after the beat.
// A new request is taken while that register is empty or being drained.
// Reset empties the list; the slot contents need no clearing.
module descending_sorted_list_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic signed [dsl_pkg::VALUE_W-1:0] req_value,
   input  logic [dsl_pkg::IDX_W-1:0]         req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [4:0]                        rsp_count,
   output logic signed [dsl_pkg::VALUE_W-1:0] rsp_read_value
);
   import dsl_pkg::*;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [1:0]         status_ff;
   logic [1:0]         status_in;
   logic [CNT_W-1:0]   rcount_ff;
   logic [VALUE_W-1:0] rvalue_ff;
   logic [VALUE_W-1:0] rvalue_in;

   logic               accept;
   logic               full;
   logic               found;
   logic               index_ok;
   cell_ctl_type       ctl;

   logic [CAPACITY-1:0] ge;
   logic [CAPACITY:0]   found_chain;
   logic [VALUE_W-1:0]  entry [CAPACITY];
   logic [VALUE_W-1:0]  read_part [CAPACITY];
   logic [VALUE_W-1:0]  read_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign full = count_ff == CNT_W'(CAPACITY);
   assign found = found_chain[CAPACITY];
   assign index_ok = CMP_W'(req_index) < CMP_W'(count_ff);
   assign found_chain[0] = 1'b0;

   assign ctl.insert_en = accept && (req_cmd == CMD_INSERT) && !full;
   assign ctl.delete_en = accept && (req_cmd == CMD_DELETE) && found;
   assign ctl.value = req_value;
   assign ctl.index = req_index;
   assign ctl.count = count_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      dsl_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_pos   (CNT_W'(i)),
         .prev_ge    ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i - 1]),
         .prev_entry ((i == 0) ? '0 : entry[(i == 0) ? 0 : i - 1]),
         .next_entry ((i == CAPACITY - 1) ? '0 : entry[(i == CAPACITY - 1) ? i : i + 1]),
         .found_in   (found_chain[i]),
         .ge_out     (ge[i]),
         .found_out  (found_chain[i+1]),
         .entry_out  (entry[i]),
         .read_out   (read_part[i])
      );
   end

   // At most one slot drives a nonzero read word.
   always_comb begin
      read_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_data = read_data | read_part[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      status_in = ST_OK;
      rvalue_in = '0;
      case (req_cmd)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         CMD_READ: begin
            if (index_ok) begin
               rvalue_in = read_data;
            end else begin
               status_in = ST_BAD_INDEX;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rcount_ff <= count_in;
         rvalue_ff <= rvalue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_count = 5'(rcount_ff);
   assign rsp_read_value = rvalue_ff;

endmodule

// ===== src/dsl_cell.sv =====
// One slot of the sorted list: holds an entry and shifts with its neighbors.
module dsl_cell (
   input  logic                           clock,
   input  dsl_pkg::cell_ctl_type          ctl,
   input  logic [dsl_pkg::CNT_W-1:0]      cell_pos,
   input  logic                           prev_ge,
   input  logic [dsl_pkg::VALUE_W-1:0]    prev_entry,
   input  logic [dsl_pkg::VALUE_W-1:0]    next_entry,
   input  logic                           found_in,
   output logic                           ge_out,
   output logic                           found_out,
   output logic [dsl_pkg::VALUE_W-1:0]    entry_out,
   output logic [dsl_pkg::VALUE_W-1:0]    read_out
);
   import dsl_pkg::*;

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               occupied;
   logic               eq;
   logic               hit;

   assign occupied = cell_pos < ctl.count;
   assign ge_out = occupied && ($signed(entry_ff) >= ctl.value);
   assign eq = occupied && (entry_ff == ctl.value);
   assign found_out = found_in | eq;
   assign entry_out = entry_ff;
   assign hit = occupied && (CMP_W'(ctl.index) == CMP_W'(cell_pos));
   assign read_out = hit ? entry_ff : '0;

   // Insert: the first slot not ahead of the value takes it, the ones behind
   // it take their upper neighbor. Delete: from the first match on, each slot
   // takes its lower neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_en && !ge_out) begin
         entry_in = prev_ge ? ctl.value : prev_entry;
      end else if (ctl.delete_en && found_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
